// ===== design/sibl_pkg.sv =====
// Shared definitions for the sorted-table binary lookup block.
// Field widths, action codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package sibl_pkg;

  // Field widths
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned POS_W     = 64;
  localparam int unsigned OFFSET_W  = 40;
  localparam int unsigned LENGTH_W  = 24;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned INDEX_W   = 10;

  // Default table depth
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // Action codes
  localparam logic ACTION_WRITE  = 1'b0;
  localparam logic ACTION_LOOKUP = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr;      // write beat accepted
    logic load;    // lookup beat accepted: latch key, start search
    logic step;    // probe missed: narrow the range
    logic ld_hit;  // probe matched: capture the position word
    logic ld_out;  // move the result into the output register
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic init_open;  // saturated count is non-zero
    logic next_open;  // narrowed range is non-empty
    logic match;      // probed key equals search key
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// ===== design/sibl_ram.sv =====
// Generic single-port RAM with registered read.
// Used for the key/position table; depends on nothing.
`timescale 1ns / 1ps

module sibl_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one access per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sibl_datapath.sv =====
// Datapath of the sorted-table lookup: table RAM, search bounds, compare,
// count register and output register. Depends on sibl_pkg and sibl_ram.
`timescale 1ns / 1ps

module sibl_datapath #(
  parameter int unsigned TABLE_DEPTH = sibl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sibl_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic [sibl_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic [sibl_pkg::KEY_W-1:0]    key_i,
  input  logic [sibl_pkg::POS_W-1:0]    position_word_i,
  input  sibl_pkg::ctrl_t               ctrl_i,
  output sibl_pkg::status_t             status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          hit_o,
  output logic [sibl_pkg::OFFSET_W-1:0] value_offset_o,
  output logic [sibl_pkg::LENGTH_W-1:0] value_length_o
);

  import sibl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned HW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WW = (HW > COUNT_W) ? HW : COUNT_W;
  localparam int unsigned RW = KEY_W + POS_W;

  logic [COUNT_W-1:0]  count_q;
  logic [KEY_W-1:0]    key_q;
  logic [HW-1:0]       lo_q, hi_q, mid_q;
  logic                res_hit_q;
  logic [POS_W-1:0]    res_pos_q;
  logic                out_valid_q;
  logic                out_hit_q;
  logic [OFFSET_W-1:0] out_offset_q;
  logic [LENGTH_W-1:0] out_length_q;

  logic [WW-1:0]       cnt_w, depth_w, slot_w, sat_w;
  logic                slot_ok;
  logic [HW-1:0]       hi_init, mid_init;
  logic [HW-1:0]       lo_n, hi_n, mid_n;
  logic [RW-1:0]       rd_data;
  logic [KEY_W-1:0]    probe_key;
  logic [POS_W-1:0]    probe_pos;
  logic                probe_gt, probe_lt;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;

  // count saturation and slot range check
  assign cnt_w    = WW'(count_q);
  assign depth_w  = WW'(TABLE_DEPTH);
  assign slot_w   = WW'(entry_index_i);
  assign slot_ok  = slot_w < depth_w;
  assign sat_w    = (cnt_w > depth_w) ? depth_w : cnt_w;
  assign hi_init  = sat_w[HW-1:0];
  assign mid_init = hi_init >> 1;

  // probe compare and next bounds
  assign probe_key = rd_data[KEY_W-1:0];
  assign probe_pos = rd_data[KEY_W +: POS_W];
  assign probe_gt  = probe_key > key_q;
  assign probe_lt  = probe_key < key_q;
  assign lo_n      = probe_lt ? (mid_q + HW'(1)) : lo_q;
  assign hi_n      = probe_gt ? mid_q : hi_q;
  assign mid_n     = lo_n + ((hi_n - lo_n) >> 1);

  assign status_o.init_open = (hi_init != '0);
  assign status_o.next_open = (lo_n < hi_n);
  assign status_o.match     = (probe_key == key_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // table port: writes, first probe at accept, later probes while stepping
  assign ram_we = ctrl_i.wr && slot_ok;
  assign ram_re = (ctrl_i.load && status_o.init_open) ||
                  (ctrl_i.step && status_o.next_open);

  always_comb begin
    if (ctrl_i.wr) begin
      ram_addr = slot_w[AW-1:0];
    end else if (ctrl_i.load) begin
      ram_addr = mid_init[AW-1:0];
    end else begin
      ram_addr = mid_n[AW-1:0];
    end
  end

  sibl_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i ({position_word_i, key_i}),
    .rdata_o (rd_data)
  );

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // search state
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q     <= key_i;
      lo_q      <= '0;
      hi_q      <= hi_init;
      mid_q     <= mid_init;
      res_hit_q <= 1'b0;
      res_pos_q <= '0;
    end else if (ctrl_i.ld_hit) begin
      res_hit_q <= 1'b1;
      res_pos_q <= probe_pos;
    end else if (ctrl_i.step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_out) begin
      out_hit_q    <= res_hit_q;
      out_offset_q <= res_pos_q[OFFSET_W-1:0];
      out_length_q <= res_pos_q[OFFSET_W +: LENGTH_W];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign value_offset_o = out_offset_q;
  assign value_length_o = out_length_q;

`ifndef NO_ASSERTIONS
  // the probed slot always lies inside the open range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.step || ctrl_i.ld_hit) |-> (lo_q <= mid_q && mid_q < hi_q))
    else $error("probe outside search range");

  // the search bound never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.step || ctrl_i.ld_hit) |-> (WW'(hi_q) <= depth_w))
    else $error("upper bound beyond table depth");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // a miss carries zero offset and length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_hit_q) |-> (out_offset_q == '0 && out_length_q == '0))
    else $error("miss with non-zero payload");
`endif

endmodule

// ===== design/sibl_ctrl.sv =====
// Controller of the sorted-table lookup: accepts beats, sequences probes,
// hands results to the output register. Depends on sibl_pkg.
`timescale 1ns / 1ps

module sibl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              action_i,
  input  sibl_pkg::status_t status_i,
  output logic              in_ready_o,
  output sibl_pkg::ctrl_t   ctrl_o
);

  import sibl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PROBE  = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACTION_WRITE) begin
            ctrl_o.wr = 1'b1;
          end else begin
            ctrl_o.load = 1'b1;
            state_d = status_i.init_open ? ST_PROBE : ST_RESULT;
          end
        end
      end
      ST_PROBE: begin
        if (status_i.match) begin
          ctrl_o.ld_hit = 1'b1;
          state_d = ST_RESULT;
        end else begin
          ctrl_o.step = 1'b1;
          if (!status_i.next_open) begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          ctrl_o.ld_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a matching probe ends the search at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE && status_i.match) |=> (state_q == ST_RESULT))
    else $error("match did not end search");

  // a lookup beat always starts a search or a direct miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACTION_LOOKUP) |=>
      (state_q == ST_PROBE || state_q == ST_RESULT))
    else $error("lookup beat dropped");

  // a write beat produces no result and keeps the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACTION_WRITE) |=> (state_q == ST_IDLE))
    else $error("write beat left idle");
`endif

endmodule

// ===== design/sorted_index_binary_lookup.sv =====
// Top level of the sorted-table binary lookup block.
// Joins sibl_ctrl and sibl_datapath; depends on sibl_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per action.
//   A write beat (action 0) stores key and position word at entry_index and
//   gives no result; slots at or beyond the depth are ignored.
//   A lookup beat (action 1) binary-searches the first entry_count entries
//   (saturated to the depth) and gives one result beat on the output channel
//   (out_valid_o / out_ready_i): hit plus offset and length, zeros on a miss.
//   A lookup makes one probe per cycle, set by the single table RAM port,
//   then loads its result into the output register. One lookup at a time:
//   the next beat is taken once the result has moved to the output register;
//   writes go one per cycle while no lookup is in progress.
//   A result waiting in the output register does not block the next beat:
//   a stalled receiver only holds a finished search until the register frees.
//   entry_count is written through cfg_we_i / cfg_wdata_i; the user must write
//   it only while idle, the block does not enforce this. Reset clears the
//   count to zero and empties the output register; table contents are undefined until written.
`timescale 1ns / 1ps

module sorted_index_binary_lookup #(
  parameter int unsigned TABLE_DEPTH = sibl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sibl_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [sibl_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic [sibl_pkg::KEY_W-1:0]    key_i,
  input  logic [sibl_pkg::POS_W-1:0]    position_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [sibl_pkg::OFFSET_W-1:0] value_offset_o,
  output logic [sibl_pkg::LENGTH_W-1:0] value_length_o
);

  import sibl_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // sequencer
  sibl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  // table, search bounds and output register
  sibl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .entry_index_i   (entry_index_i),
    .key_i           (key_i),
    .position_word_i (position_word_i),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .hit_o           (hit_o),
    .value_offset_o  (value_offset_o),
    .value_length_o  (value_length_o)
  );

endmodule

// ===== bench/sorted_index_binary_lookup_tb.sv =====
// Self-checking bench for sorted_index_binary_lookup: table writes, lookups and
// entry_count settings, each result compared with a table mirror kept here.
// Depends on sibl_pkg and the block's RTL only.
`timescale 1ns / 1ps

module sorted_index_binary_lookup_tb;
  import sibl_pkg::*;

  localparam int unsigned DEPTH         = TABLE_DEPTH_DEF;
  localparam int unsigned RANDOM_BEATS  = 1050;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_PHASE    = 0;
  localparam int unsigned RUN_LIMIT_NS  = 2000000;

  // Key layouts the table can be filled with
  typedef enum logic [1:0] {
    LAYOUT_ASCEND,
    LAYOUT_TOP,
    LAYOUT_PAIRED,
    LAYOUT_SCRAMBLED
  } layout_e;

  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
  } lookup_res_t;

  // Mirror of the table and count; predicts each lookup and checks results
  class table_mirror;
    logic [KEY_W-1:0]   slot_key [DEPTH];
    logic [POS_W-1:0]   slot_pos [DEPTH];
    logic [COUNT_W-1:0] entry_count = '0;
    lookup_res_t        awaited_results [$];
    int unsigned        mismatches = 0;

    // Binary search over the saturated count; every probed slot lands in trail
    function int find_slot(logic [KEY_W-1:0] key, ref int unsigned trail [$]);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = (entry_count > DEPTH) ? DEPTH : entry_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        trail.push_back(mid);
        if (slot_key[mid] > key) hi = mid;
        else if (slot_key[mid] < key) lo = mid + 1;
        else return mid;
      end
      return -1;
    endfunction

    function void note_beat(logic act, logic [INDEX_W-1:0] idx, logic [KEY_W-1:0] key,
                            logic [POS_W-1:0] pos);
      int unsigned trail [$];
      int          found;
      lookup_res_t res;
      if (act == ACTION_WRITE) begin
        if (idx < DEPTH) begin
          slot_key[idx] = key;
          slot_pos[idx] = pos;
        end
        return;
      end
      res = '0;
      found = find_slot(key, trail);
      if (found >= 0) begin
        res.hit    = 1'b1;
        res.offset = slot_pos[found][OFFSET_W-1:0];
        res.length = slot_pos[found][POS_W-1 -: LENGTH_W];
      end
      awaited_results.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch, %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic hit, logic [OFFSET_W-1:0] offset, logic [LENGTH_W-1:0] length);
      lookup_res_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result beat with no lookup pending (hit %0b)", hit));
        return;
      end
      want = awaited_results.pop_front();
      if (hit !== want.hit)
        report($sformatf("hit got %0b want %0b", hit, want.hit));
      if (offset !== want.offset)
        report($sformatf("value_offset got %h want %h", offset, want.offset));
      if (length !== want.length)
        report($sformatf("value_length got %h want %h", length, want.length));
    endtask
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata_i     = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic                action_i        = ACTION_WRITE;
  logic [INDEX_W-1:0]  entry_index_i   = '0;
  logic [KEY_W-1:0]    key_i           = '0;
  logic [POS_W-1:0]    position_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic                hit_o;
  logic [OFFSET_W-1:0] value_offset_o;
  logic [LENGTH_W-1:0] value_length_o;

  table_mirror mirror = new();

  // Stimulus state
  layout_e          layout        = LAYOUT_ASCEND;
  logic [KEY_W-1:0] key_base      = '0;
  logic [KEY_W-1:0] key_step      = 64'd2;
  bit               fresh [DEPTH];
  bit               no_idle       = 1'b0;
  bit               hold_request  = 1'b0;
  int unsigned      beats_sent    = 0;

  sorted_index_binary_lookup #(
    .TABLE_DEPTH (DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .entry_index_i   (entry_index_i),
    .key_i           (key_i),
    .position_word_i (position_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .value_offset_o  (value_offset_o),
    .value_length_o  (value_length_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Key that the current layout puts in a slot
  function automatic logic [KEY_W-1:0] layout_key(int unsigned slot);
    case (layout)
      LAYOUT_ASCEND: return key_base + 64'(slot) * key_step;
      LAYOUT_TOP:    return {KEY_W{1'b1}} - 64'(DEPTH - 1 - slot) * key_step;
      LAYOUT_PAIRED: return key_base + 64'(slot >> 2) * key_step;
      default:       return {$urandom, $urandom};
    endcase
  endfunction

  // One input beat; valid stays high into the next beat when no gap is drawn
  task automatic send_beat(input logic act, input logic [INDEX_W-1:0] idx,
                           input logic [KEY_W-1:0] key, input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    entry_index_i   <= idx;
    key_i           <= key;
    position_word_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mirror.note_beat(act, idx, key, pos);
    beats_sent++;
  endtask

  // Write a slot with the layout's key; position word now and then at an extreme
  task automatic put_entry(input int unsigned slot);
    logic [POS_W-1:0] pos;
    case ($urandom_range(0, 9))
      0:       pos = '0;
      1:       pos = '1;
      default: pos = {$urandom, $urandom};
    endcase
    send_beat(ACTION_WRITE, INDEX_W'(slot), layout_key(slot), pos);
    fresh[slot] = 1'b1;
  endtask

  // Fill every slot the search would probe before sending the lookup itself
  task automatic search_for(input logic [KEY_W-1:0] key);
    int unsigned trail [$];
    int          stale;
    do begin
      stale = -1;
      trail.delete();
      void'(mirror.find_slot(key, trail));
      foreach (trail[t])
        if (stale < 0 && !fresh[trail[t]]) stale = trail[t];
      if (stale >= 0) put_entry(stale);
    end while (stale >= 0);
    send_beat(ACTION_LOOKUP, INDEX_W'($urandom), key, {$urandom, $urandom});
  endtask

  // Wait until every lookup has answered and any write has landed
  task automatic settle();
    in_valid_i <= 1'b0;
    while (mirror.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror.entry_count = value;
  endtask

  // Result side: random stalls, one long hold-off when asked for
  initial begin : result_sink
    int unsigned pause;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      pause = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_request) begin
        pause        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (pause != 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      mirror.check_result(hit_o, value_offset_o, value_length_o);
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned      pick;
    int unsigned      span;
    int unsigned      roll;
    int unsigned      slot;
    int unsigned      top;
    logic [COUNT_W-1:0] count;
    logic [KEY_W-1:0] probe_key;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset: both lookups miss; ignored fields at both extremes
    send_beat(ACTION_LOOKUP, '0, '0, '0);
    send_beat(ACTION_LOOKUP, '1, '1, '1);

    // Small sorted table holding the smallest and largest keys
    send_beat(ACTION_WRITE, 10'd0, 64'd0, '1);
    send_beat(ACTION_WRITE, 10'd1, 64'd5, '0);
    send_beat(ACTION_WRITE, 10'd2, '1, {24'hA5C3E1, 40'h5A_3C1E_0F96});
    send_beat(ACTION_WRITE, '1, '1, {$urandom, $urandom});
    settle();
    write_count(11'd3);
    send_beat(ACTION_LOOKUP, '0, 64'd0, '0);
    send_beat(ACTION_LOOKUP, '0, 64'd5, '0);
    send_beat(ACTION_LOOKUP, '0, '1, '0);
    send_beat(ACTION_LOOKUP, '0, 64'd3, '0);
    send_beat(ACTION_LOOKUP, '0, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_beat(ACTION_LOOKUP, '0, 64'd6, '0);

    // Equal keys in slots 0 and 1: the middle probe answers first
    send_beat(ACTION_WRITE, 10'd1, 64'd0, 64'h0000_0100_0000_0001);
    send_beat(ACTION_LOOKUP, '0, 64'd0, '0);

    // Unsorted: 100 sits in slot 0 but the probe path never reaches it
    send_beat(ACTION_WRITE, 10'd0, 64'd100, {$urandom, $urandom});
    send_beat(ACTION_LOOKUP, '0, 64'd100, '0);
    send_beat(ACTION_LOOKUP, '0, 64'd0, '0);

    // Random phases, each with its own layout, count and idling
    beats_sent = 0;
    for (int phase = 0; beats_sent < RANDOM_BEATS; phase++) begin
      settle();
      pick = (phase == 0) ? 0 : $urandom_range(0, 9);
      if (pick != 9) begin
        if (pick < 4)      layout = LAYOUT_ASCEND;
        else if (pick < 6) layout = LAYOUT_TOP;
        else if (pick < 8) layout = LAYOUT_PAIRED;
        else               layout = LAYOUT_SCRAMBLED;
        key_base = {2'b00, 30'($urandom), 32'($urandom)};
        key_step = {13'd0, 19'($urandom), 32'($urandom)} + 64'd2;
        if ($urandom_range(0, 3) == 0) begin
          key_base = '0;
          key_step = 64'($urandom_range(2, 9));
        end
        foreach (fresh[s]) fresh[s] = 1'b0;
      end

      case ($urandom_range(0, 9))
        0:       count = '0;
        1:       count = 11'd1;
        2:       count = 11'd1023;
        3:       count = 11'd1024;
        4:       count = 11'($urandom_range(1025, 2047));
        5:       count = '1;
        6, 7:    count = 11'($urandom_range(2, 32));
        default: count = 11'($urandom_range(33, 1022));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      span    = $urandom_range(30, 90);
      // first phase: count far past the depth, so the search saturates
      if (phase == 0) count = '1;
      // receiver holds off while the sender keeps the input busy
      if (phase == HOLD_PHASE) begin
        if (count == '0) count = 11'd512;
        no_idle      = 1'b1;
        span         = 80;
        hold_request = 1'b1;
      end
      write_count(count);

      top = (count > DEPTH) ? DEPTH : count;
      for (int k = 0; k < span && beats_sent < RANDOM_BEATS; k++) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
          // stray key breaks the ordering for the rest of the phase
          slot = $urandom_range(0, DEPTH - 1);
          send_beat(ACTION_WRITE, INDEX_W'(slot), {$urandom, $urandom}, {$urandom, $urandom});
          fresh[slot] = 1'b1;
        end else if (roll < 3) begin
          put_entry($urandom_range(0, DEPTH - 1));
        end else begin
          if (top == 0 || roll >= 17) begin
            if (roll == 19)      probe_key = '0;
            else if (roll == 18) probe_key = '1;
            else                 probe_key = {$urandom, $urandom};
          end else begin
            slot      = $urandom_range(0, top - 1);
            probe_key = fresh[slot] ? mirror.slot_key[slot] : layout_key(slot);
            // neighbours of a stored key usually miss
            if (roll == 15)      probe_key = probe_key + 64'd1;
            else if (roll == 16) probe_key = probe_key - 64'd1;
          end
          search_for(probe_key);
        end
      end
    end

    settle();
    if (mirror.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sibl_pkg.sv
design/sibl_ram.sv
design/sibl_datapath.sv
design/sibl_ctrl.sv
design/sorted_index_binary_lookup.sv
bench/sorted_index_binary_lookup_tb.sv
